FILE: sv/cht_pkg.sv
// Shared types, codes and constants of the calibrated heater thermostat.
`timescale 1ns / 1ps
package cht_pkg;

  // Field widths.
  localparam int unsigned AdcW   = 12;
  localparam int unsigned TempW  = 10;
  localparam int unsigned PowerW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers and the setpoint state.
  localparam logic [AdcW-1:0]   AdcCalLowRst   = 12'd241;
  localparam logic [AdcW-1:0]   AdcCalHighRst  = 12'd1575;
  localparam logic [TempW-1:0]  TempCalLowRst  = 10'd150;
  localparam logic [TempW-1:0]  TempCalHighRst = 10'd330;
  localparam logic [TempW-1:0]  WarmTargetRst  = 10'd150;
  localparam logic [PowerW-1:0] PowerFullRst   = 16'd100;
  localparam logic [TempW-1:0]  SetpointRst    = 10'd300;

  // Offset of the raised target in degrees and the largest ADC code.
  localparam logic [TempW:0]  RaiseDelta = 11'd30;
  localparam logic [AdcW-1:0] AdcMax     = 12'd4095;

  // Quotient bits produced by the restoring divider, one per cycle.
  localparam int unsigned DivSteps = 12;
  localparam int unsigned DivCntW  = 4;

  // Operating mode codes.
  localparam logic [1:0] ModeNormal = 2'd0;
  localparam logic [1:0] ModeWarm   = 2'd1;
  localparam logic [1:0] ModeHeat   = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgAdcCalLow   = 3'd0,
    CfgAdcCalHigh  = 3'd1,
    CfgTempCalLow  = 3'd2,
    CfgTempCalHigh = 3'd3,
    CfgWarmTarget  = 3'd4,
    CfgPowerFull   = 3'd5
  } cfg_idx_e;

  // Which calibration map a pass of the datapath computes.
  typedef enum logic [1:0] {
    JobSp    = 2'd0,
    JobRaise = 2'd1,
    JobWarm  = 2'd2
  } map_job_e;

  // Input transaction payload.
  typedef struct packed {
    logic [AdcW-1:0]  adc_sample;
    logic [TempW-1:0] setpoint_temp;
    logic [1:0]       mode;
    logic             high_power;
  } in_item_t;

  // Output transaction payload.
  typedef struct packed {
    logic [PowerW-1:0] power_level;
    logic              heater_on;
    logic              control_type;
    logic [AdcW-1:0]   active_target_adc;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     latch_in;
    logic     mul_a;
    logic     mul_b;
    logic     sum;
    logic     norm;
    logic     div_step;
    logic     store;
    logic     decide;
    map_job_e job;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sp_changed;
    logic warm_mode;
  } dp_stat_t;

endpackage

FILE: sv/cht_datapath.sv
// Datapath: configuration, setpoint state, calibration map with divider, and result register.
`timescale 1ns / 1ps
module cht_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cht_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cht_pkg::CfgDataW-1:0]  cfg_data_i,
  input  cht_pkg::in_item_t             in_item_i,
  input  cht_pkg::dp_cmd_t              cmd_i,
  output cht_pkg::dp_stat_t             stat_o,
  output cht_pkg::out_item_t            out_item_o
);
  import cht_pkg::*;

  // Configuration registers.
  logic [AdcW-1:0]   adc_cal_low_q, adc_cal_high_q;
  logic [TempW-1:0]  temp_cal_low_q, temp_cal_high_q, warm_target_q;
  logic [PowerW-1:0] power_full_q;

  // Architectural state.
  logic [TempW-1:0] stored_sp_q;
  logic [AdcW-1:0]  sp_adc_q, raise_adc_q;
  logic             reg_type_q;

  // Working registers.
  in_item_t           in_q;
  logic [AdcW-1:0]    warm_adc_q;
  logic signed [24:0] prod_a_q;
  logic signed [23:0] prod_b_q;
  logic signed [25:0] num_q;
  logic [21:0]        rem_q, dvs_q;
  logic [AdcW-1:0]    quo_q;
  logic               neg_q, sat_q, den_zero_q;
  out_item_t          out_q;

  // Combinational terms.
  logic [TempW:0]     map_t;
  logic signed [11:0] dt;
  logic signed [12:0] da;
  logic signed [10:0] den;
  logic [10:0]        den_abs;
  logic [9:0]         den_mag;
  logic [25:0]        num_mag;
  logic [AdcW-1:0]    map_res;
  logic [AdcW-1:0]    target;
  logic [PowerW-1:0]  power;
  logic               below;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_cal_low_q   <= AdcCalLowRst;
      adc_cal_high_q  <= AdcCalHighRst;
      temp_cal_low_q  <= TempCalLowRst;
      temp_cal_high_q <= TempCalHighRst;
      warm_target_q   <= WarmTargetRst;
      power_full_q    <= PowerFullRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgAdcCalLow:   adc_cal_low_q   <= cfg_data_i[AdcW-1:0];
        CfgAdcCalHigh:  adc_cal_high_q  <= cfg_data_i[AdcW-1:0];
        CfgTempCalLow:  temp_cal_low_q  <= cfg_data_i[TempW-1:0];
        CfgTempCalHigh: temp_cal_high_q <= cfg_data_i[TempW-1:0];
        CfgWarmTarget:  warm_target_q   <= cfg_data_i[TempW-1:0];
        CfgPowerFull:   power_full_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Temperature fed to the calibration map for the current job.
  always_comb begin
    unique case (cmd_i.job)
      JobSp:    map_t = {1'b0, in_q.setpoint_temp};
      JobRaise: map_t = {1'b0, in_q.setpoint_temp} + RaiseDelta;
      JobWarm:  map_t = {1'b0, warm_target_q};
      default:  map_t = '0;
    endcase
  end

  // Signed differences of the two-point line.
  assign dt  = $signed({1'b0, map_t}) - $signed({2'b00, temp_cal_low_q});
  assign da  = $signed({1'b0, adc_cal_high_q}) - $signed({1'b0, adc_cal_low_q});
  assign den = $signed({1'b0, temp_cal_high_q}) - $signed({1'b0, temp_cal_low_q});

  // Magnitudes for the unsigned divider.
  assign den_abs = den[10] ? 11'(-den) : 11'(den);
  assign den_mag = den_abs[9:0];
  assign num_mag = num_q[25] ? 26'(-num_q) : 26'(num_q);

  // Final map value: equal points, negative quotient and overflow are special.
  always_comb begin
    priority if (den_zero_q) begin
      map_res = adc_cal_low_q;
    end else if (neg_q) begin
      map_res = '0;
    end else if (sat_q) begin
      map_res = AdcMax;
    end else begin
      map_res = quo_q;
    end
  end

  // Target selection and power decision.
  always_comb begin
    priority if (in_q.mode == ModeWarm) begin
      target = warm_adc_q;
    end else if (in_q.mode == ModeHeat && in_q.high_power) begin
      target = raise_adc_q;
    end else begin
      target = sp_adc_q;
    end
  end

  assign below = target > in_q.adc_sample;
  assign power = below ? (reg_type_q ? (power_full_q >> 1) : power_full_q) : '0;

  // Setpoint state and regulation type.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_sp_q <= SetpointRst;
      sp_adc_q    <= '0;
      raise_adc_q <= '0;
      reg_type_q  <= 1'b0;
    end else begin
      if (cmd_i.store && cmd_i.job == JobSp) begin
        stored_sp_q <= in_q.setpoint_temp;
        sp_adc_q    <= map_res;
      end
      if (cmd_i.store && cmd_i.job == JobRaise) begin
        raise_adc_q <= map_res;
      end
      if (cmd_i.decide && !below) begin
        reg_type_q <= 1'b1;
      end
    end
  end

  // Map arithmetic: two products, sum, normalize, then restoring division.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      in_q <= in_item_i;
    end
    if (cmd_i.mul_a) begin
      prod_a_q <= 25'(dt) * 25'(da);
    end
    if (cmd_i.mul_b) begin
      prod_b_q <= 24'($signed({1'b0, adc_cal_low_q})) * 24'(den);
    end
    if (cmd_i.sum) begin
      num_q <= {prod_a_q[24], prod_a_q} + {{2{prod_b_q[23]}}, prod_b_q};
    end
    if (cmd_i.norm) begin
      neg_q      <= num_q[25] ^ den[10];
      den_zero_q <= (den == '0);
      sat_q      <= num_mag >= {4'b0000, den_mag, 12'b0};
      rem_q      <= num_mag[21:0];
      dvs_q      <= {1'b0, den_mag, 11'b0};
      quo_q      <= '0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= dvs_q) begin
        rem_q <= rem_q - dvs_q;
        quo_q <= {quo_q[AdcW-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[AdcW-2:0], 1'b0};
      end
      dvs_q <= dvs_q >> 1;
    end
    if (cmd_i.store && cmd_i.job == JobWarm) begin
      warm_adc_q <= map_res;
    end
    if (cmd_i.decide) begin
      out_q.power_level       <= power;
      out_q.heater_on         <= (power != '0);
      out_q.control_type      <= reg_type_q | ~below;
      out_q.active_target_adc <= target;
    end
  end

  assign stat_o.sp_changed = (in_q.setpoint_temp != stored_sp_q);
  assign stat_o.warm_mode  = (in_q.mode == ModeWarm);
  assign out_item_o        = out_q;

endmodule

FILE: sv/cht_ctrl.sv
// Controller: sequences the map passes and the decision, and owns both handshakes.
`timescale 1ns / 1ps
module cht_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  cht_pkg::dp_stat_t  stat_i,
  output cht_pkg::dp_cmd_t   cmd_o
);
  import cht_pkg::*;

  typedef enum logic [8:0] {
    StIdle   = 9'b000000001,
    StPlan   = 9'b000000010,
    StMulA   = 9'b000000100,
    StMulB   = 9'b000001000,
    StSum    = 9'b000010000,
    StNorm   = 9'b000100000,
    StDiv    = 9'b001000000,
    StStore  = 9'b010000000,
    StDecide = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic [2:0]         pend_q, pend_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               slot_free;
  map_job_e           job;

  // Pending map jobs, served setpoint first, then raised, then warm.
  always_comb begin
    priority if (pend_q[0]) begin
      job = JobSp;
    end else if (pend_q[1]) begin
      job = JobRaise;
    end else begin
      job = JobWarm;
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  // Next state and command decode.
  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.job   = job;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = StPlan;
        end
      end
      StPlan: begin
        pend_d = {stat_i.warm_mode, stat_i.sp_changed, stat_i.sp_changed};
        if (stat_i.warm_mode || stat_i.sp_changed) begin
          state_d = StMulA;
        end else begin
          state_d = StDecide;
        end
      end
      StMulA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = StMulB;
      end
      StMulB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = StSum;
      end
      StSum: begin
        cmd_o.sum = 1'b1;
        state_d   = StNorm;
      end
      StNorm: begin
        cmd_o.norm = 1'b1;
        cnt_d      = '0;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StStore;
        end
      end
      StStore: begin
        cmd_o.store = 1'b1;
        unique case (job)
          JobSp:    pend_d[0] = 1'b0;
          JobRaise: pend_d[1] = 1'b0;
          JobWarm:  pend_d[2] = 1'b0;
          default:  pend_d    = '0;
        endcase
        if (pend_d != '0) begin
          state_d = StMulA;
        end else begin
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (slot_free) begin
          cmd_o.decide = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/calibrated_heater_thermostat.sv
// Top level of the calibrated heater thermostat: controller and datapath.
// No calibration map is needed when the setpoint is unchanged and the mode is not warm; a new
// setpoint needs two calibration maps (setpoint and raised target) and warm mode needs one more.
// Each map pass is two multiplies, an add, a normalize and a restoring divider of 12 quotient bits.
// The next transaction is taken while a result waits; the decision stalls until the output slot is free.
// Reset (asynchronous, active low) loads the register defaults and the setpoint state at once.
`timescale 1ns / 1ps
module calibrated_heater_thermostat (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cht_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cht_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cht_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cht_pkg::out_item_t            out_item_o
);
  import cht_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer and handshakes.
  cht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  cht_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_item_o  (out_item_o)
  );

endmodule
